@@ src/crt_pkg.sv @@
`timescale 1ns / 1ps

package crt_pkg;

	localparam int VALUE_WIDTH_DEF = 128;
	localparam int RES_W           = 8;
	localparam int MOD_W           = 8;
	localparam int INV_T_W         = MOD_W + 2;
	localparam int TDATA_IN_W      = RES_W + MOD_W;
	localparam int HALF_W          = 64;
	localparam int TDATA_OUT_W     = 2 * HALF_W;

	typedef logic [MOD_W-1:0] mod_t;

	typedef struct packed {
		logic start;
		mod_t a;
		mod_t m;
	} inv_req_t;

	typedef struct packed {
		logic done;
		mod_t inv;
	} inv_rsp_t;

	// (2*r + b) mod p, with r already below p
	function automatic mod_t mod_dbl_add(mod_t r, logic b, mod_t p);
		logic [MOD_W:0] t;
		t = {r, b};
		if (t >= {1'b0, p}) begin
			t = t - {1'b0, p};
		end
		return t[MOD_W-1:0];
	endfunction

	// (a + b) mod p, with a and b already below p
	function automatic mod_t mod_add(mod_t a, mod_t b, mod_t p);
		logic [MOD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, p}) begin
			s = s - {1'b0, p};
		end
		return s[MOD_W-1:0];
	endfunction

endpackage

@@ src/crt_inv.sv @@
`timescale 1ns / 1ps

module crt_inv (
	input  logic              clk,
	input  logic              arst_n,
	input  crt_pkg::inv_req_t req,
	output crt_pkg::inv_rsp_t rsp
);
	import crt_pkg::*;

	localparam int QW = 2 * MOD_W;
	localparam int KW = $clog2(MOD_W);

	logic                      busy_q;
	mod_t                      r_q;
	mod_t                      nr_q;
	mod_t                      m_q;
	logic signed [INV_T_W-1:0] t_q;
	logic signed [INV_T_W-1:0] nt_q;

	logic [KW-1:0]             k;
	logic [QW-1:0]             nr_sh;
	logic signed [QW-1:0]      nt_sh;
	mod_t                      r_sub;
	logic signed [INV_T_W-1:0] t_sub;
	logic signed [INV_T_W-1:0] t_fix;

	// largest shift of nr that still fits under r: one quotient bit per cycle, except on a swap
	always_comb begin
		k = '0;
		for (int i = 0; i < MOD_W; i++) begin
			if (({{MOD_W{1'b0}}, nr_q} << i) <= {{MOD_W{1'b0}}, r_q}) begin
				k = KW'(i);
			end
		end
	end

	assign nr_sh = {{MOD_W{1'b0}}, nr_q} << k;
	assign nt_sh = QW'(nt_q) <<< k;
	assign r_sub = r_q - nr_sh[MOD_W-1:0];
	assign t_sub = t_q - nt_sh[INV_T_W-1:0];
	assign t_fix = (t_q < 0) ? t_q + $signed({2'b00, m_q}) : t_q;

	always_comb begin
		rsp.done = busy_q && (nr_q == '0);
		rsp.inv  = (r_q == mod_t'(1)) ? t_fix[MOD_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (rsp.done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q  <= req.m;
			nr_q <= req.a;
			m_q  <= req.m;
			t_q  <= '0;
			nt_q <= INV_T_W'(1);
		end else if (busy_q && (nr_q != '0)) begin
			if (r_q >= nr_q) begin
				r_q <= r_sub;
				t_q <= t_sub;
			end else begin
				r_q  <= nr_q;
				nr_q <= r_q;
				t_q  <= nt_q;
				nt_q <= t_q;
			end
		end
	end

endmodule

@@ src/crt_signed_reconstruct_unit.sv @@
`timescale 1ns / 1ps

// Signed CRT reconstruction (Garner mixed radix) over a stream of residues.
// Input stream s_axis: one transaction per (residue, modulus) pair, tlast on
// the final pair of a number. Output stream m_axis: one transaction per
// number, the signed 128-bit value, sent after the pair marked tlast.
// Running value and product are VALUE_WIDTH bits and processed one bit per
// cycle through shift registers. Each pair is reduced, then the inverse is
// found by extended Euclid steps (a subtract or a swap each), then the digit
// and the multiply-accumulate follow; the last pair adds the symmetric fold.
// A zero modulus skips reduction, inverse and digit. The two bit passes over
// VALUE_WIDTH bits (residue reduction and the multiply-accumulate) take most
// of the time of a pair. The result enters the output register from the emit
// state once that register is free.
// s_axis_tready is high only while idle; a pair is processed fully first.
// The engine keeps taking pairs while the receiver stalls and only waits if
// a second result is ready before the first has been taken.
// Reset clears the running value to 0 and the product to 1, drops tvalid.
module crt_signed_reconstruct_unit #(
	parameter int VALUE_WIDTH = crt_pkg::VALUE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [crt_pkg::TDATA_IN_W-1:0]  s_axis_tdata,  // residue, modulus
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [crt_pkg::TDATA_OUT_W-1:0] m_axis_tdata   // value_low, value_high
);
	import crt_pkg::*;

	localparam int W     = VALUE_WIDTH;
	localparam int CNT_W = $clog2(W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_RESFIX,
		ST_INV,
		ST_STEP,
		ST_ACCUM,
		ST_FOLD,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [W-1:0]            val_q;
	logic [W-1:0]            prod_q;
	logic                    out_valid_q;
	logic [TDATA_OUT_W-1:0]  out_data_q;

	mod_t                    mod_q;
	mod_t                    mult_q;
	logic                    last_q;
	logic                    neg_q;
	logic [RES_W-1:0]        ra_sh_q;
	mod_t                    ra_q;
	mod_t                    rv_q;
	mod_t                    rp_q;
	mod_t                    delta_q;
	mod_t                    inv_sh_q;
	mod_t                    acc_q;
	mod_t                    step_q;
	logic [MOD_W:0]          c1_q;
	mod_t                    c2_q;
	logic                    vprev_q;
	logic                    gt_q;
	logic                    bor_q;

	logic                    in_fire;
	logic                    out_free;
	logic                    cnt_end;
	logic signed [RES_W-1:0] in_res;
	mod_t                    in_mod;
	logic [RES_W-1:0]        in_abs;
	mod_t                    red_v;
	mod_t                    red_p;
	mod_t                    red_a;
	mod_t                    rm;
	mod_t                    delta;
	mod_t                    acc2;
	mod_t                    acc3;
	logic [MOD_W+1:0]        x;
	logic [MOD_W:0]          y;
	logic                    gt_mid;
	logic                    gt_end;
	logic [1:0]              f;
	inv_req_t                inv_req;
	inv_rsp_t                inv_rsp;

	assign in_res        = s_axis_tdata[RES_W-1:0];
	assign in_mod        = s_axis_tdata[TDATA_IN_W-1:RES_W];
	assign in_abs        = in_res[RES_W-1] ? RES_W'(-in_res) : in_res;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign cnt_end       = (cnt_q == CNT_W'(W - 1));
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// residue reduction, msb first
	assign red_v = mod_dbl_add(rv_q, val_q[W-1], mod_q);
	assign red_p = mod_dbl_add(rp_q, prod_q[W-1], mod_q);
	assign red_a = mod_dbl_add(ra_q, ra_sh_q[RES_W-1], mod_q);

	// signed residue mod p, then delta = (res - value) mod p
	assign rm    = (neg_q && (ra_q != '0)) ? mod_q - ra_q : ra_q;
	assign delta = (rm >= rv_q) ? rm - rv_q
		: MOD_W'({1'b0, rm} + {1'b0, mod_q} - {1'b0, rv_q});

	// step = delta * inv mod p, one bit of inv per cycle
	assign acc2 = mod_dbl_add(acc_q, 1'b0, mod_q);
	assign acc3 = mod_add(acc2, inv_sh_q[MOD_W-1] ? delta_q : '0, mod_q);

	// value += product * step and product *= p, lsb first
	assign x = (MOD_W+2)'(prod_q[0] ? step_q : '0) + (MOD_W+2)'(val_q[0])
		+ (MOD_W+2)'(c1_q);
	assign y = (MOD_W+1)'(prod_q[0] ? mult_q : '0) + (MOD_W+1)'(c2_q);

	// value > product/2: half bit i-1 is product bit i, top half bit is zero
	assign gt_mid = ((cnt_q != '0) && (vprev_q != y[0])) ? vprev_q : gt_q;
	assign gt_end = x[0] | gt_mid;

	// serial subtract of the product when the fold is taken
	assign f = {1'b0, val_q[0]} - {1'b0, gt_q & prod_q[0]} - {1'b0, bor_q};

	always_comb begin
		inv_req.start = (state_q == ST_RESFIX);
		inv_req.a     = rp_q;
		inv_req.m     = mod_q;
	end

	crt_inv u_inv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (inv_req),
		.rsp    (inv_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			val_q       <= '0;
			prod_q      <= W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_fire) begin
						state_q <= (in_mod == '0) ? ST_ACCUM : ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					val_q  <= {val_q[W-2:0], val_q[W-1]};
					prod_q <= {prod_q[W-2:0], prod_q[W-1]};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_end) begin
						state_q <= ST_RESFIX;
					end
				end
				ST_RESFIX: begin
					state_q <= ST_INV;
				end
				ST_INV: begin
					cnt_q <= '0;
					if (inv_rsp.done) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (cnt_q == CNT_W'(MOD_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_ACCUM;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ACCUM: begin
					val_q  <= {x[0], val_q[W-1:1]};
					prod_q <= {y[0], prod_q[W-1:1]};
					if (cnt_end) begin
						cnt_q   <= '0;
						state_q <= last_q ? ST_FOLD : ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FOLD: begin
					val_q  <= {f[0], val_q[W-1:1]};
					prod_q <= {prod_q[0], prod_q[W-1:1]};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_end) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						val_q   <= '0;
						prod_q  <= W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mod_q   <= in_mod;
			mult_q  <= (in_mod == '0) ? mod_t'(1) : in_mod;
			last_q  <= s_axis_tlast;
			neg_q   <= in_res[RES_W-1];
			ra_sh_q <= in_abs;
			ra_q    <= '0;
			rv_q    <= '0;
			rp_q    <= '0;
			step_q  <= '0;
			c1_q    <= '0;
			c2_q    <= '0;
			vprev_q <= 1'b0;
			gt_q    <= 1'b0;
		end
		case (state_q)
			ST_REDUCE: begin
				rv_q <= red_v;
				rp_q <= red_p;
				if (cnt_q < CNT_W'(RES_W)) begin
					ra_q    <= red_a;
					ra_sh_q <= {ra_sh_q[RES_W-2:0], 1'b0};
				end
			end
			ST_RESFIX: begin
				delta_q <= delta;
			end
			ST_INV: begin
				inv_sh_q <= inv_rsp.inv;
				acc_q    <= '0;
			end
			ST_STEP: begin
				acc_q    <= acc3;
				inv_sh_q <= {inv_sh_q[MOD_W-2:0], 1'b0};
				if (cnt_q == CNT_W'(MOD_W - 1)) begin
					step_q  <= acc3;
					c1_q    <= '0;
					c2_q    <= '0;
					vprev_q <= 1'b0;
					gt_q    <= 1'b0;
				end
			end
			ST_ACCUM: begin
				c1_q    <= x[MOD_W+1:1];
				c2_q    <= y[MOD_W:1];
				vprev_q <= x[0];
				gt_q    <= cnt_end ? gt_end : gt_mid;
				bor_q   <= 1'b0;
			end
			ST_FOLD: begin
				bor_q <= f[1];
			end
			ST_EMIT: begin
				if (out_free) begin
					out_data_q <= TDATA_OUT_W'($signed(val_q));
				end
			end
			default: begin
			end
		endcase
	end

	// residues of value and product are fully reduced before the inverse
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESFIX |-> (rv_q < mod_q) && (rp_q < mod_q))
		else $error("residue not reduced below modulus");

	assert property (@(posedge clk) disable iff (!arst_n)
		inv_rsp.done && (mod_q != '0) |-> inv_rsp.inv < mod_q)
		else $error("inverse out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACCUM && mod_q != '0 |-> step_q < mod_q)
		else $error("mixed radix digit out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside of emit");

endmodule
